// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared sizes, register map offsets and codes of the interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pic_pkg;

    localparam int NUM_SOURCES   = 96;
    localparam int PRIORITY_BITS = 7;
    localparam int ID_BITS       = $clog2(NUM_SOURCES);
    localparam int WORD_COUNT    = (NUM_SOURCES + 31) / 32;
    localparam int WORD_BITS     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic [21:0] PENDING_BASE = 22'h001000;
    localparam logic [21:0] ENABLE_BASE  = 22'h002000;
    localparam logic [21:0] CONTEXT_BASE = 22'h200000;
    localparam logic [21:0] CLAIM_ADDR   = 22'h200004;
    localparam logic [21:0] WORDS_SPAN   = 22'(4 * WORD_COUNT);

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LEVEL = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PRE    = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_RDWAIT = 6'b001000,
        ST_POST   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

endpackage

// ===== rtl/pic_ram.sv =====
// ----------------------------------------------------------------------------
// pic_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/platform_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// platform_interrupt_controller
// Single-context platform interrupt controller; priorities live in a RAM.
// Each beat passes EXEC, a scan of the priority RAM over all sources (POST)
// and DONE before its result is registered; a priority read adds RDWAIT after
// EXEC, and a claim read also scans the RAM (PRE) before EXEC.
// One beat is in flight at a time; the next is taken once the result is registered.
// Synchronous active-low reset clears the state, the source bit vectors and the
// threshold; priority entries read as zero until first written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module platform_interrupt_controller
    import pic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bus_address[21:0], write_data[53:22], line_number[60:54], line_level[61]
    input  logic [63:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], irq_request[32]
    output logic [39:0] m_tdata
);

    state_t state_reg, state_next;

    logic [1:0]  kind_reg;
    logic [21:0] addr_reg;
    logic [31:0] data_reg;
    logic [6:0]  line_reg;
    logic        level_reg;

    logic [NUM_SOURCES-1:0] pend_reg, pend_next;
    logic [NUM_SOURCES-1:0] en_reg, en_next;
    logic [NUM_SOURCES-1:0] isv_reg, isv_next;
    logic [NUM_SOURCES-1:0] lvl_reg, lvl_next;
    logic [NUM_SOURCES-1:0] pvld_reg, pvld_next;
    logic [PRIORITY_BITS-1:0] thr_reg, thr_next;

    logic [ID_BITS:0]         scan_idx_reg, scan_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [ID_BITS-1:0]       cmp_id_reg, cmp_id_next;
    logic [ID_BITS-1:0]       best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;

    logic [31:0] rd_reg, rd_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_rd_reg, out_rd_next;
    logic        out_irq_reg, out_irq_next;

    logic                     ram_we;
    logic [ID_BITS-1:0]       ram_waddr, ram_raddr;
    logic [PRIORITY_BITS-1:0] ram_wdata, ram_rdata;

    pic_ram #(
        .WIDTH (PRIORITY_BITS),
        .DEPTH (NUM_SOURCES)
    ) u_prio_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address decode of the held beat.
    logic [21:0]               addr_w;
    logic                      in_prio, prio_id_ok, in_pend, in_en;
    logic [ID_BITS-1:0]        prio_id;
    logic [WORD_BITS-1:0]      pend_w, en_w;
    logic [WORD_COUNT*32-1:0]  pend_pad, en_pad;
    logic [21:0]               pend_off, en_off;
    logic                      line_ok, cpl_ok;
    logic [ID_BITS-1:0]        line_id, cpl_id;
    logic                      scan_last;
    logic [PRIORITY_BITS-1:0]  cmp_prio;
    logic                      cand;

    assign addr_w     = {addr_reg[21:2], 2'b00};
    assign in_prio    = addr_w < PENDING_BASE;
    assign prio_id_ok = (addr_w[21:2] != 20'd0) && (32'(addr_w[21:2]) < NUM_SOURCES);
    assign prio_id    = ID_BITS'(addr_w[21:2]);
    assign pend_off   = addr_w - PENDING_BASE;
    assign en_off     = addr_w - ENABLE_BASE;
    assign in_pend    = (addr_w >= PENDING_BASE) && (addr_w < PENDING_BASE + WORDS_SPAN);
    assign in_en      = (addr_w >= ENABLE_BASE) && (addr_w < ENABLE_BASE + WORDS_SPAN);
    assign pend_w     = WORD_BITS'(pend_off[21:2]);
    assign en_w       = WORD_BITS'(en_off[21:2]);
    assign pend_pad   = (WORD_COUNT*32)'(pend_reg);
    assign en_pad     = (WORD_COUNT*32)'(en_reg);
    assign line_ok    = (line_reg != 7'd0) && (32'(line_reg) < NUM_SOURCES);
    assign line_id    = ID_BITS'(line_reg);
    assign cpl_id     = ID_BITS'(data_reg);
    assign cpl_ok     = (data_reg != 32'd0) && (data_reg < 32'(NUM_SOURCES))
                        && en_reg[cpl_id] && isv_reg[cpl_id];

    assign scan_last  = cmp_valid_reg && (32'(cmp_id_reg) == NUM_SOURCES - 1);
    assign cmp_prio   = pvld_reg[cmp_id_reg] ? ram_rdata : '0;
    assign cand       = cmp_valid_reg && pend_reg[cmp_id_reg] && en_reg[cmp_id_reg]
                        && (cmp_prio > thr_reg) && (cmp_prio > best_prio_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_irq_reg, out_rd_reg};

    always_comb begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        en_next        = en_reg;
        isv_next       = isv_reg;
        lvl_next       = lvl_reg;
        pvld_next      = pvld_reg;
        thr_next       = thr_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_id_next    = cmp_id_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_irq_next   = out_irq_reg;
        ram_we         = 1'b0;
        ram_waddr      = prio_id;
        ram_wdata      = data_reg[PRIORITY_BITS-1:0];
        ram_raddr      = scan_idx_reg[ID_BITS-1:0];

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                scan_idx_next  = (ID_BITS+1)'(1);
                best_id_next   = '0;
                best_prio_next = '0;
                rd_next        = '0;
                if (s_tvalid) begin
                    if (s_tuser == KIND_READ
                        && {s_tdata[21:2], 2'b00} == CLAIM_ADDR) begin
                        state_next = ST_PRE;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_PRE, ST_POST: begin
                if (32'(scan_idx_reg) < NUM_SOURCES) begin
                    cmp_valid_next = 1'b1;
                    cmp_id_next    = scan_idx_reg[ID_BITS-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                if (cand) begin
                    best_id_next   = cmp_id_reg;
                    best_prio_next = cmp_prio;
                end
                if (scan_last) begin
                    state_next = (state_reg == ST_PRE) ? ST_EXEC : ST_DONE;
                end
            end
            ST_EXEC: begin
                scan_idx_next = (ID_BITS+1)'(1);
                state_next    = ST_POST;
                case (kind_reg)
                    KIND_READ: begin
                        if (in_prio) begin
                            if (prio_id_ok) begin
                                ram_raddr  = prio_id;
                                state_next = ST_RDWAIT;
                            end
                        end else if (in_pend) begin
                            rd_next = pend_pad[32*pend_w +: 32];
                        end else if (in_en) begin
                            rd_next = en_pad[32*en_w +: 32];
                        end else if (addr_w == CONTEXT_BASE) begin
                            rd_next = 32'(thr_reg);
                        end else if (addr_w == CLAIM_ADDR) begin
                            rd_next = 32'(best_id_reg);
                            if (best_id_reg != '0) begin
                                pend_next[best_id_reg] = 1'b0;
                                isv_next[best_id_reg]  = 1'b1;
                            end
                        end
                    end
                    KIND_WRITE: begin
                        if (in_prio) begin
                            if (prio_id_ok) begin
                                ram_we             = 1'b1;
                                pvld_next[prio_id] = 1'b1;
                            end
                        end else if (in_en) begin
                            for (int i = 1; i < NUM_SOURCES; i++) begin
                                if (32'(en_w) == i / 32) begin
                                    en_next[i] = data_reg[i % 32];
                                end
                            end
                        end else if (addr_w == CONTEXT_BASE) begin
                            thr_next = data_reg[PRIORITY_BITS-1:0];
                        end else if (addr_w == CLAIM_ADDR) begin
                            if (cpl_ok) begin
                                isv_next[cpl_id] = 1'b0;
                                if (lvl_reg[cpl_id]) begin
                                    pend_next[cpl_id] = 1'b1;
                                end
                            end
                        end
                    end
                    KIND_LEVEL: begin
                        if (line_ok) begin
                            lvl_next[line_id] = level_reg;
                            if (level_reg && !isv_reg[line_id]) begin
                                pend_next[line_id] = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                best_id_next   = '0;
                best_prio_next = '0;
            end
            ST_RDWAIT: begin
                rd_next    = 32'(pvld_reg[prio_id] ? ram_rdata : '0);
                state_next = ST_POST;
            end
            ST_DONE: begin
                // The output register may still hold the previous result.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_irq_next   = (best_id_reg != '0);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= '0;
            en_reg        <= '0;
            isv_reg       <= '0;
            lvl_reg       <= '0;
            pvld_reg      <= '0;
            thr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            en_reg        <= en_next;
            isv_reg       <= isv_next;
            lvl_reg       <= lvl_next;
            pvld_reg      <= pvld_next;
            thr_reg       <= thr_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            addr_reg  <= s_tdata[21:0];
            data_reg  <= s_tdata[53:22];
            line_reg  <= s_tdata[60:54];
            level_reg <= s_tdata[61];
        end
        scan_idx_reg  <= scan_idx_next;
        cmp_id_reg    <= cmp_id_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        rd_reg        <= rd_next;
        out_rd_reg    <= out_rd_next;
        out_irq_reg   <= out_irq_next;
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the platform interrupt controller. A scoreboard
// class keeps its own copy of priorities, pending, enable, in-service and line
// levels, predicts read data and the interrupt request for every accepted
// input beat, and compares each result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import pic_pkg::*;
;

    class plic_scoreboard;
        logic [PRIORITY_BITS-1:0] prio [NUM_SOURCES];
        bit pend [NUM_SOURCES];
        bit enab [NUM_SOURCES];
        bit claimed [NUM_SOURCES];
        bit level [NUM_SOURCES];
        logic [PRIORITY_BITS-1:0] threshold;
        logic [32:0] expected_q [$];
        int mismatches;

        function new();
            for (int i = 0; i < NUM_SOURCES; i++) begin
                prio[i] = '0; pend[i] = 0; enab[i] = 0; claimed[i] = 0; level[i] = 0;
            end
            threshold = '0;
            mismatches = 0;
        endfunction

        function int unsigned winner();
            int unsigned best;
            logic [PRIORITY_BITS-1:0] best_prio;
            best = 0;
            best_prio = '0;
            for (int id = 1; id < NUM_SOURCES; id++) begin
                if (pend[id] && enab[id] && prio[id] > threshold && prio[id] > best_prio) begin
                    best = id;
                    best_prio = prio[id];
                end
            end
            return best;
        endfunction

        function logic [31:0] gather(bit which_enable, int unsigned word);
            logic [31:0] v;
            int unsigned id;
            v = '0;
            for (int b = 0; b < 32; b++) begin
                id = word * 32 + b;
                if (id != 0 && id < NUM_SOURCES)
                    v[b] = which_enable ? enab[id] : pend[id];
            end
            return v;
        endfunction

        function void note_input(kind_t kind, logic [21:0] address, logic [31:0] data,
                                 logic [6:0] line, bit lvl);
            logic [21:0] a;
            logic [31:0] rd;
            int unsigned id;
            a = {address[21:2], 2'b00};
            rd = '0;
            case (kind)
                KIND_READ: begin
                    if (a < PENDING_BASE) begin
                        id = a >> 2;
                        if (id != 0 && id < NUM_SOURCES) rd = 32'(prio[id]);
                    end else if (a < PENDING_BASE + WORDS_SPAN) begin
                        rd = gather(0, (a - PENDING_BASE) >> 2);
                    end else if (a >= ENABLE_BASE && a < ENABLE_BASE + WORDS_SPAN) begin
                        rd = gather(1, (a - ENABLE_BASE) >> 2);
                    end else if (a == CONTEXT_BASE) begin
                        rd = 32'(threshold);
                    end else if (a == CLAIM_ADDR) begin
                        id = winner();
                        if (id != 0) begin
                            pend[id] = 0;
                            claimed[id] = 1;
                        end
                        rd = id;
                    end
                end
                KIND_WRITE: begin
                    if (a < PENDING_BASE) begin
                        id = a >> 2;
                        if (id != 0 && id < NUM_SOURCES) prio[id] = data[PRIORITY_BITS-1:0];
                    end else if (a >= ENABLE_BASE && a < ENABLE_BASE + WORDS_SPAN) begin
                        for (int b = 0; b < 32; b++) begin
                            id = ((a - ENABLE_BASE) >> 2) * 32 + b;
                            if (id != 0 && id < NUM_SOURCES) enab[id] = data[b];
                        end
                    end else if (a == CONTEXT_BASE) begin
                        threshold = data[PRIORITY_BITS-1:0];
                    end else if (a == CLAIM_ADDR) begin
                        if (data != 0 && data < NUM_SOURCES && enab[data] && claimed[data]) begin
                            claimed[data] = 0;
                            if (level[data]) pend[data] = 1;
                        end
                    end
                end
                KIND_LEVEL: begin
                    if (line != 0 && line < NUM_SOURCES) begin
                        level[line] = lvl;
                        if (lvl && !claimed[line]) pend[line] = 1;
                    end
                end
                default: ;
            endcase
            expected_q.push_back({winner() != 0, rd});
        endfunction

        function void check_result(logic [39:0] beat);
            logic [32:0] want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", beat);
                return;
            end
            want = expected_q.pop_front();
            if (beat[31:0] !== want[31:0] || beat[32] !== want[32]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: read_data exp %h got %h, irq exp %b got %b",
                             want[31:0], beat[31:0], want[32], beat[32]);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    plic_scoreboard board;
    int  cycles;
    bit  calm;

    platform_interrupt_controller DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        calm = 0;
        cycles = 0;
        board = new();
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls, except during the calm stretch.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            m_tready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // The beat stays valid after its handshake until the next one is driven,
    // so that back-to-back beats never drop tvalid.
    task automatic send(kind_t kind, logic [21:0] address, logic [31:0] data,
                        logic [6:0] line, bit lvl);
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {2'b00, lvl, line, data, address};
        do @(posedge aclk); while (!s_tready);
        board.note_input(kind, address, data, line, lvl);
    endtask

    task automatic wr(logic [21:0] address, logic [31:0] data);
        send(KIND_WRITE, address, data, 7'd0, 0);
    endtask

    task automatic rd(logic [21:0] address);
        send(KIND_READ, address, $urandom, 7'($urandom), 1'($urandom));
    endtask

    task automatic lvl(logic [6:0] line, bit value);
        send(KIND_LEVEL, 22'($urandom), $urandom, line, value);
    endtask

    // Addresses biased toward mapped registers of the controller.
    function automatic logic [21:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1: return 22'(4 * $urandom_range(0, NUM_SOURCES + 2)) | 22'($urandom_range(0, 3));
            2:    return PENDING_BASE + 22'(4 * $urandom_range(0, WORD_COUNT));
            3, 4: return ENABLE_BASE + 22'(4 * $urandom_range(0, WORD_COUNT));
            5:    return CONTEXT_BASE;
            6, 7: return CLAIM_ADDR;
            8:    return 22'($urandom);
            default: return 22'h3FFFFC | 22'($urandom_range(0, 3));
        endcase
    endfunction

    initial begin
        logic [21:0] a;
        logic [31:0] d;
        int unsigned pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: extremes and each special case.
        calm = 1;
        wr(22'd4, 32'hFFFF_FFFF);                 // wide data keeps low bits
        wr(22'd0, 32'h7F);                        // reserved source
        wr(22'(4 * (NUM_SOURCES - 1)) | 22'd3, 32'd5); // unaligned address
        wr(ENABLE_BASE, 32'hFFFF_FFFF);
        wr(ENABLE_BASE + 22'(4 * (WORD_COUNT - 1)), 32'hFFFF_FFFF);
        wr(ENABLE_BASE + WORDS_SPAN, 32'hFFFF_FFFF); // past the last word
        lvl(7'd1, 1);
        lvl(7'(NUM_SOURCES - 1), 1);
        lvl(7'd0, 1);                             // bad line numbers
        lvl(7'd127, 1);
        wr(PENDING_BASE, 32'hFFFF_FFFF);          // pending is read-only
        rd(PENDING_BASE);
        rd(PENDING_BASE + 22'(4 * (WORD_COUNT - 1)));
        rd(22'd4);
        rd(CLAIM_ADDR);                           // highest priority wins
        rd(CLAIM_ADDR);
        rd(CLAIM_ADDR);                           // nothing left to claim
        wr(CLAIM_ADDR, 32'd0);                    // mismatched completions
        wr(CLAIM_ADDR, 32'd200);
        wr(CLAIM_ADDR, 32'd1);                    // line still high: pending again
        wr(CONTEXT_BASE, 32'hFFFF_FFFF);
        rd(CONTEXT_BASE);
        send(KIND_NONE, 22'h3FFFFF, 32'hFFFF_FFFF, 7'h7F, 1);
        rd(22'h3FFFFC);
        wr(CONTEXT_BASE, 32'd0);

        // Random part; beats 200 to 449 run without idling or result stalls.
        for (int n = 0; n < 1500; n++) begin
            calm = (n >= 200 && n < 450);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                lvl(7'($urandom_range(0, NUM_SOURCES + 3)), 1'($urandom));
            end else if (pick < 65) begin
                rd(pick_address());
            end else begin
                a = pick_address();
                d = $urandom;
                if (a == CLAIM_ADDR && $urandom_range(0, 3) != 0)
                    d = $urandom_range(0, NUM_SOURCES + 1);
                else if (a < PENDING_BASE || a == CONTEXT_BASE)
                    d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
                wr(a, d);
            end
        end
        s_tvalid <= 0;
        calm = 1;

        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
